### design/uart_pkg.sv
package uart_pkg;

    localparam int DATA_BITS = 8;
    localparam int BYTE_W    = 8;
    localparam int TICK_W    = 16;
    localparam int PHASE_W   = 4;
    localparam int PADDR_W   = 3;
    localparam int PDATA_W   = 32;

    localparam logic [PHASE_W-1:0] PH_IDLE  = PHASE_W'(0);
    localparam logic [PHASE_W-1:0] PH_START = PHASE_W'(1);
    localparam logic [PHASE_W-1:0] PH_DATA0 = PHASE_W'(2);
    localparam logic [PHASE_W-1:0] PH_LAST  = PHASE_W'(DATA_BITS + 1);
    localparam logic [PHASE_W-1:0] PH_STOP  = PHASE_W'(DATA_BITS + 2);

    localparam logic [TICK_W-1:0] BIT_TICKS_RESET = TICK_W'(16);

    localparam logic REG_BIT_TICKS = 1'b0;

    typedef logic [BYTE_W-1:0]  byte_t;
    typedef logic [TICK_W-1:0]  tick_t;
    typedef logic [PHASE_W-1:0] phase_t;

    typedef struct packed {
        logic  rx_level;
        logic  send;
        byte_t send_byte;
    } item_t;

    typedef struct packed {
        logic  tx_level;
        logic  tx_busy;
        logic  rx_valid;
        byte_t rx_byte;
    } res_t;

endpackage

### design/uart_in_if.sv
interface uart_in_if;
    logic             valid;
    logic             ready;
    logic             rx_level;
    logic             send;
    uart_pkg::byte_t  send_byte;

    modport source (output valid, output rx_level, output send, output send_byte, input ready);
    modport sink   (input valid, input rx_level, input send, input send_byte, output ready);
endinterface

### design/uart_out_if.sv
interface uart_out_if;
    logic             valid;
    logic             ready;
    logic             tx_level;
    logic             tx_busy;
    logic             rx_valid;
    uart_pkg::byte_t  rx_byte;

    modport source (output valid, output tx_level, output tx_busy, output rx_valid,
                    output rx_byte, input ready);
    modport sink   (input valid, input tx_level, input tx_busy, input rx_valid,
                    input rx_byte, output ready);
endinterface

### design/uart_core.sv
module uart_core (
    input  logic            clk,
    input  logic            rst_n,
    input  uart_pkg::tick_t bit_ticks,
    input  logic            step,
    input  uart_pkg::item_t item,
    output uart_pkg::res_t  res
);
    import uart_pkg::*;

    byte_t  tx_shift_reg, tx_shift_next;
    phase_t tx_phase_reg, tx_phase_next;
    tick_t  tx_timer_reg, tx_timer_next;
    byte_t  rx_shift_reg, rx_shift_next;
    phase_t rx_phase_reg, rx_phase_next;
    tick_t  rx_timer_reg, rx_timer_next;

    tick_t  period;
    tick_t  half_period;
    phase_t tx_ph;
    phase_t rx_ph;
    phase_t rx_pos;
    tick_t  tx_inc;
    tick_t  rx_inc;
    logic   tx_level;
    logic   tx_busy;
    logic   rx_valid;
    byte_t  rx_byte;

    assign period      = (bit_ticks == '0) ? TICK_W'(1) : bit_ticks;
    assign half_period = bit_ticks >> 1;
    assign res         = {tx_level, tx_busy, rx_valid, rx_byte};

    // transmitter
    always_comb
    begin
        tx_ph         = (tx_phase_reg > PH_STOP) ? PH_IDLE : tx_phase_reg;
        tx_shift_next = tx_shift_reg;
        tx_timer_next = tx_timer_reg;
        tx_level      = 1'b1;
        tx_busy       = 1'b0;
        if (tx_ph == PH_IDLE && item.send)
        begin
            tx_shift_next = item.send_byte;
            tx_ph         = PH_START;
            tx_timer_next = '0;
        end
        tx_inc        = TICK_W'(tx_timer_next + TICK_W'(1));
        tx_phase_next = tx_ph;
        if (tx_ph != PH_IDLE)
        begin
            tx_busy = 1'b1;
            if (tx_ph == PH_START)
                tx_level = 1'b0;
            else if (tx_ph <= PH_LAST)
                tx_level = tx_shift_next[0];
            else
                tx_level = 1'b1;
            tx_timer_next = tx_inc;
            if (tx_inc >= period)
            begin
                tx_timer_next = '0;
                if (tx_ph >= PH_DATA0 && tx_ph <= PH_LAST)
                    tx_shift_next = tx_shift_next >> 1;
                tx_phase_next = (tx_ph >= PH_STOP) ? PH_IDLE : PHASE_W'(tx_ph + PHASE_W'(1));
            end
        end
    end

    // receiver
    always_comb
    begin
        rx_ph         = (rx_phase_reg > PH_STOP) ? PH_IDLE : rx_phase_reg;
        rx_phase_next = rx_ph;
        rx_shift_next = rx_shift_reg;
        rx_timer_next = rx_timer_reg;
        rx_inc        = TICK_W'(rx_timer_reg + TICK_W'(1));
        rx_pos        = PHASE_W'(rx_ph - PH_DATA0);
        rx_valid      = 1'b0;
        rx_byte       = '0;
        if (rx_ph == PH_IDLE)
        begin
            if (!item.rx_level)
            begin
                rx_phase_next = PH_START;
                rx_timer_next = '0;
                rx_shift_next = '0;
            end
        end
        else if (rx_ph == PH_START)
        begin
            rx_timer_next = rx_inc;
            if (rx_inc >= half_period)
            begin
                rx_timer_next = '0;
                rx_phase_next = PH_DATA0;
            end
        end
        else if (rx_ph <= PH_LAST)
        begin
            rx_timer_next = rx_inc;
            if (rx_inc >= period)
            begin
                rx_timer_next = '0;
                if (rx_pos < PHASE_W'(BYTE_W) && item.rx_level)
                    rx_shift_next[rx_pos[$clog2(BYTE_W)-1:0]] = 1'b1;
                rx_phase_next = PHASE_W'(rx_ph + PHASE_W'(1));
                if (rx_phase_next == PH_STOP)
                begin
                    rx_valid = 1'b1;
                    rx_byte  = rx_shift_next;
                end
            end
        end
        else
        begin
            if (item.rx_level)
                rx_phase_next = PH_IDLE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tx_shift_reg <= '0;
            tx_phase_reg <= PH_IDLE;
            tx_timer_reg <= '0;
            rx_shift_reg <= '0;
            rx_phase_reg <= PH_IDLE;
            rx_timer_reg <= '0;
        end
        else if (step)
        begin
            tx_shift_reg <= tx_shift_next;
            tx_phase_reg <= tx_phase_next;
            tx_timer_reg <= tx_timer_next;
            rx_shift_reg <= rx_shift_next;
            rx_phase_reg <= rx_phase_next;
            rx_timer_reg <= rx_timer_next;
        end
    end

    a_tx_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
        tx_phase_reg <= PH_STOP)
        else $error("tx phase out of range");

    a_rx_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
        rx_phase_reg <= PH_STOP)
        else $error("rx phase out of range");

    a_rx_valid_stop: assert property (@(posedge clk) disable iff (!rst_n)
        (step && res.rx_valid) |=> rx_phase_reg == PH_STOP)
        else $error("byte flagged without entering stop wait");

    a_tx_start_low: assert property (@(posedge clk) disable iff (!rst_n)
        (step && tx_phase_reg == PH_IDLE && item.send) |-> (res.tx_busy && !res.tx_level))
        else $error("send did not start a low start bit");

endmodule

### design/uart_obuf.sv
module uart_obuf (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  uart_pkg::res_t din,
    output logic           space,
    uart_out_if.source     result
);
    import uart_pkg::*;

    res_t       head_reg, head_next;
    res_t       tail_reg, tail_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       pop;

    assign pop          = result.valid && result.ready;
    assign space        = (cnt_reg != 2'd2);
    assign result.valid = (cnt_reg != 2'd0);
    assign result.tx_level = head_reg.tx_level;
    assign result.tx_busy  = head_reg.tx_busy;
    assign result.rx_valid = head_reg.rx_valid;
    assign result.rx_byte  = head_reg.rx_byte;

    always_comb
    begin
        head_next = head_reg;
        tail_next = tail_reg;
        cnt_next  = cnt_reg;
        case (cnt_reg)
            2'd0:
            begin
                if (push)
                begin
                    head_next = din;
                    cnt_next  = 2'd1;
                end
            end
            2'd1:
            begin
                if (push && pop)
                    head_next = din;
                else if (push)
                begin
                    tail_next = din;
                    cnt_next  = 2'd2;
                end
                else if (pop)
                    cnt_next = 2'd0;
            end
            2'd2:
            begin
                if (pop)
                begin
                    head_next = tail_reg;
                    cnt_next  = 2'd1;
                end
            end
            default:
            begin
                cnt_next = 2'd0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= 2'd0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        head_reg <= head_next;
        tail_reg <= tail_next;
    end

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg != 2'd3)
        else $error("output buffer count corrupt");

    a_drain_order: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == 2'd2 && pop) |=> (cnt_reg == 2'd1 && head_reg == $past(tail_reg)))
        else $error("second word not moved to head");

endmodule

### design/uart_8n1_transceiver.sv
// full-duplex 8n1 serial port, stepped one time-base tick per input word
// item channel: one word per tick, carrying the sampled rx line level and an
//   optional send request with its byte; a send is taken only when the
//   transmitter is idle, otherwise ignored
// result channel: exactly one word per item: tx line level and busy flag for
//   that tick, plus rx_valid/rx_byte on the tick the last data bit is sampled
// config: apb-style port, bit_ticks at address 0 (ticks per bit, reset 16)
// result of an item: registered in the buffer, behind any words still held
// throughput: one item per cycle while the result buffer has space; the tick
//   state update is a single pass of counter and compare logic between the
//   state registers and the two-word result buffer
// reset: both transmitter and receiver idle, line driven high, buffer empty
// stall: if the result side holds ready low the buffer absorbs two words,
//   then item ready drops until a word is taken; nothing is lost
module uart_8n1_transceiver (
    input  logic                        clk,
    input  logic                        rst_n,
    uart_in_if.sink                     item,
    uart_out_if.source                  result,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [uart_pkg::PADDR_W-1:0] paddr,
    input  logic [uart_pkg::PDATA_W-1:0] pwdata,
    output logic [uart_pkg::PDATA_W-1:0] prdata,
    output logic                        pready
);
    import uart_pkg::*;

    tick_t bit_ticks_reg;
    logic  step;
    logic  space;
    item_t cur;
    res_t  res;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_BIT_TICKS) ? PDATA_W'(bit_ticks_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            bit_ticks_reg <= BIT_TICKS_RESET;
        else if (psel && penable && pwrite && paddr[2] == REG_BIT_TICKS)
            bit_ticks_reg <= pwdata[TICK_W-1:0];
    end

    assign item.ready    = space;
    assign step          = item.valid && space;
    assign cur.rx_level  = item.rx_level;
    assign cur.send      = item.send;
    assign cur.send_byte = item.send_byte;

    uart_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .bit_ticks (bit_ticks_reg),
        .step      (step),
        .item      (cur),
        .res       (res)
    );

    uart_obuf u_obuf (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (step),
        .din    (res),
        .space  (space),
        .result (result)
    );

endmodule

### verif/tb.sv
`timescale 1ns / 100ps

module tb;
    import uart_pkg::*;

    localparam int QUIET_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 4;
    localparam logic [PADDR_W-1:0] BIT_TICKS_ADDR = PADDR_W'(4 * REG_BIT_TICKS);

    logic               clk;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    uart_in_if  item_if ();
    uart_out_if res_if ();

    uart_8n1_transceiver i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .item    (item_if),
        .result  (res_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // line model state, reset values
    tick_t  line_bit_ticks = BIT_TICKS_RESET;
    phase_t tx_ph  = PH_IDLE;
    tick_t  tx_tmr = '0;
    byte_t  tx_sr  = '0;
    phase_t rx_ph  = PH_IDLE;
    tick_t  rx_tmr = '0;
    byte_t  rx_sr  = '0;

    res_t   due_ticks_q[$];
    logic   rx_wave_q[$];
    bit     idling = 1'b1;
    int     n_mismatch = 0;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic res_t tick_uart(input item_t it);
        res_t  r;
        tick_t per;
        per = (line_bit_ticks == '0) ? tick_t'(1) : line_bit_ticks;
        r = '{tx_level: 1'b1, tx_busy: 1'b0, rx_valid: 1'b0, rx_byte: '0};

        if (tx_ph > PH_STOP)
            tx_ph = PH_IDLE;
        if (tx_ph == PH_IDLE && it.send)
        begin
            tx_sr  = it.send_byte;
            tx_ph  = PH_START;
            tx_tmr = '0;
        end
        if (tx_ph != PH_IDLE)
        begin
            r.tx_busy = 1'b1;
            if (tx_ph == PH_START)
                r.tx_level = 1'b0;
            else if (tx_ph <= PH_LAST)
                r.tx_level = tx_sr[0];
            tx_tmr = tx_tmr + 1'b1;
            if (tx_tmr >= per)
            begin
                tx_tmr = '0;
                if (tx_ph >= PH_DATA0 && tx_ph <= PH_LAST)
                    tx_sr = tx_sr >> 1;
                tx_ph = (tx_ph == PH_STOP) ? PH_IDLE : tx_ph + 1'b1;
            end
        end

        if (rx_ph > PH_STOP)
            rx_ph = PH_IDLE;
        if (rx_ph == PH_IDLE)
        begin
            if (!it.rx_level)
            begin
                rx_ph  = PH_START;
                rx_tmr = '0;
                rx_sr  = '0;
            end
        end
        else if (rx_ph == PH_START)
        begin
            rx_tmr = rx_tmr + 1'b1;
            if (rx_tmr >= (line_bit_ticks >> 1))
            begin
                rx_tmr = '0;
                rx_ph  = PH_DATA0;
            end
        end
        else if (rx_ph <= PH_LAST)
        begin
            rx_tmr = rx_tmr + 1'b1;
            if (rx_tmr >= per)
            begin
                rx_tmr = '0;
                if (int'(rx_ph - PH_DATA0) < BYTE_W && it.rx_level)
                    rx_sr[3'(rx_ph - PH_DATA0)] = 1'b1;
                rx_ph = rx_ph + 1'b1;
                if (rx_ph == PH_STOP)
                begin
                    r.rx_valid = 1'b1;
                    r.rx_byte  = rx_sr;
                end
            end
        end
        else if (it.rx_level)
        begin
            rx_ph = PH_IDLE;
        end
        return r;
    endfunction

    always @(posedge clk)
    begin : tick_checker
        item_t it;
        res_t  want;
        if (rst_n && item_if.valid && item_if.ready)
        begin
            it.rx_level  = item_if.rx_level;
            it.send      = item_if.send;
            it.send_byte = item_if.send_byte;
            due_ticks_q.push_back(tick_uart(it));
        end
        if (rst_n && res_if.valid && res_if.ready)
        begin
            if (due_ticks_q.size() == 0)
            begin
                n_mismatch++;
                $error("result word with no tick pending");
            end
            else
            begin
                want = due_ticks_q.pop_front();
                if (res_if.tx_level !== want.tx_level)
                begin
                    n_mismatch++;
                    $error("tx_level: expected %0d, got %0d", want.tx_level, res_if.tx_level);
                end
                if (res_if.tx_busy !== want.tx_busy)
                begin
                    n_mismatch++;
                    $error("tx_busy: expected %0d, got %0d", want.tx_busy, res_if.tx_busy);
                end
                if (res_if.rx_valid !== want.rx_valid)
                begin
                    n_mismatch++;
                    $error("rx_valid: expected %0d, got %0d", want.rx_valid, res_if.rx_valid);
                end
                if (res_if.rx_byte !== want.rx_byte)
                begin
                    n_mismatch++;
                    $error("rx_byte: expected 0x%02h, got 0x%02h", want.rx_byte, res_if.rx_byte);
                end
            end
        end
    end

    initial
    begin : result_stall
        int hold;
        hold = 0;
        res_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold > 0)
            begin
                hold--;
                res_if.ready <= 1'b0;
            end
            else if (idling && $urandom_range(0, 5) == 0)
            begin
                hold = $urandom_range(0, 3);
                res_if.ready <= 1'b0;
            end
            else
            begin
                res_if.ready <= 1'b1;
            end
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || psel || (item_if.valid && item_if.ready)
                || (res_if.valid && res_if.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("FAIL uart_8n1_transceiver");
        $finish;
    end

    task automatic push_tick(input logic rx_level, input logic send, input byte_t send_byte);
        if (idling && $urandom_range(0, 7) == 0)
        begin
            item_if.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        item_if.valid     <= 1'b1;
        item_if.rx_level  <= rx_level;
        item_if.send      <= send;
        item_if.send_byte <= send_byte;
        do @(posedge clk); while (!item_if.ready);
    endtask

    task automatic wait_drained();
        item_if.valid <= 1'b0;
        @(posedge clk);
        while (due_ticks_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // write then read back; upper data bits carry junk that must be dropped
    task automatic set_bit_ticks(input tick_t value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= BIT_TICKS_ADDR;
        pwdata  <= PDATA_W'(($urandom << TICK_W) | value);
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        line_bit_ticks = value;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (prdata !== PDATA_W'(value))
        begin
            n_mismatch++;
            $error("bit_ticks: expected %0d, got %0d", value, prdata);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // queue up rx line levels: mostly clean frames, some cut short, some noise
    task automatic plan_rx_line(input int per);
        byte_t b;
        int    kind;
        kind = $urandom_range(0, 9);
        b    = byte_t'($urandom);
        repeat ($urandom_range(0, 2 * per)) rx_wave_q.push_back(1'b1);
        if (kind < 7)
        begin
            repeat (per) rx_wave_q.push_back(1'b0);
            for (int i = 0; i < BYTE_W; i++)
                repeat (per) rx_wave_q.push_back(b[i]);
            repeat (per) rx_wave_q.push_back(1'b1);
        end
        else if (kind < 9)
        begin
            repeat (per) rx_wave_q.push_back(1'b0);
            repeat ($urandom_range(1, 4 * per)) rx_wave_q.push_back(1'($urandom_range(0, 1)));
        end
        else
        begin
            repeat ($urandom_range(1, 8)) rx_wave_q.push_back(1'($urandom_range(0, 1)));
        end
    endtask

    task automatic run_random_ticks(input int n_ticks);
        int per;
        per = (line_bit_ticks == '0) ? 1 : int'(line_bit_ticks);
        repeat (n_ticks)
        begin
            if (rx_wave_q.size() == 0)
                plan_rx_line(per);
            push_tick(rx_wave_q.pop_front(), 1'($urandom_range(0, 5) == 0), byte_t'($urandom));
        end
    endtask

    task automatic test_reset_rate();
        run_random_ticks(100);
    endtask

    task automatic test_fast_bit_rates();
        wait_drained();
        set_bit_ticks('0);
        // all-ones byte out while 0x80 comes in; mid-frame send dropped
        for (int t = 0; t < 12; t++)
            push_tick(1'(t >= 9), 1'(t == 0 || t == 3 || t == 11), (t == 0) ? 8'hFF : 8'h00);
        wait_drained();
        set_bit_ticks(tick_t'(1));
        for (int t = 0; t < 12; t++)
            push_tick(1'(t != 0), 1'(t == 5 || t == 11), (t == 5) ? 8'h5A : 8'hC3);
    endtask

    task automatic test_slowest_bit_rate();
        wait_drained();
        set_bit_ticks('1);
        for (int t = 0; t < 20; t++)
            push_tick(1'(t < 2 || t > 5), 1'(t == 0), 8'hA5);
    endtask

    task automatic test_random_traffic();
        tick_t rates[5]  = '{2, 3, 7, 5, 4};
        int    counts[5] = '{300, 250, 150, 200, 150};
        for (int k = 0; k < 5; k++)
        begin
            wait_drained();
            idling = (k != 4);
            set_bit_ticks(rates[k]);
            run_random_ticks(counts[k]);
        end
    endtask

    initial
    begin
        rst_n             <= 1'b0;
        psel              <= 1'b0;
        penable           <= 1'b0;
        pwrite            <= 1'b0;
        paddr             <= '0;
        pwdata            <= '0;
        item_if.valid     <= 1'b0;
        item_if.rx_level  <= 1'b1;
        item_if.send      <= 1'b0;
        item_if.send_byte <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_rate();
        test_fast_bit_rates();
        test_slowest_bit_rate();
        test_random_traffic();
        wait_drained();

        if (n_mismatch == 0)
            $display("PASS uart_8n1_transceiver");
        else
            $display("FAIL uart_8n1_transceiver");
        $finish;
    end

endmodule
